// ----- hdl/rc5_ir_frame_transmitter_assert.svh -----
// Assertion macros for the RC5 frame transmitter checker.
// No dependencies; included by the checker file.
`ifndef RC5_IR_FRAME_TRANSMITTER_ASSERT_SVH
`define RC5_IR_FRAME_TRANSMITTER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define RC5TX_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define RC5TX_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/rc5tx_pkg.sv -----
// Shared types and constants for the RC5 frame transmitter.
// No dependencies; imported by the register file, the engine, the top level and the testbench.
package rc5tx_pkg;

   // Register indexes on the configuration port
   localparam logic [1:0] REG_CARRIER_HIGH  = 2'd0;
   localparam logic [1:0] REG_CARRIER_PER   = 2'd1;
   localparam logic [1:0] REG_PULSES_HALF   = 2'd2;
   localparam logic [1:0] REG_SPACE_TICKS   = 2'd3;

   // Register reset values
   localparam logic [7:0]  CARRIER_HIGH_RST = 8'd7;
   localparam logic [7:0]  CARRIER_PER_RST  = 8'd28;
   localparam logic [5:0]  PULSES_HALF_RST  = 6'd32;
   localparam logic [11:0] SPACE_TICKS_RST  = 12'd889;

   // Index of the last frame bit
   localparam logic [3:0] LAST_BIT = 4'd13;

   // Input mode codes
   localparam logic MODE_TICK  = 1'b0;
   localparam logic MODE_START = 1'b1;

   typedef struct packed {
      logic [7:0]  carrier_high;
      logic [7:0]  carrier_period;
      logic [5:0]  pulses_per_half;
      logic [11:0] space_ticks;
   } cfg_type;

   typedef struct packed {
      logic ir_level;
      logic busy_res;
      logic frame_done;
      logic start_refused;
   } result_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SEND = 2'b10
   } tx_state_type;

endpackage

// ----- hdl/rc5tx_csr.sv -----
// Configuration register file of the RC5 frame transmitter (APB-style).
// Depends on rc5tx_pkg.
module rc5tx_csr
   import rc5tx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   // Decode the write transaction
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_CARRIER_HIGH: cfg_in.carrier_high    = csr_pwdata[7:0];
            REG_CARRIER_PER:  cfg_in.carrier_period  = csr_pwdata[7:0];
            REG_PULSES_HALF:  cfg_in.pulses_per_half = csr_pwdata[5:0];
            REG_SPACE_TICKS:  cfg_in.space_ticks     = csr_pwdata[11:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.carrier_high    <= CARRIER_HIGH_RST;
         cfg_ff.carrier_period  <= CARRIER_PER_RST;
         cfg_ff.pulses_per_half <= PULSES_HALF_RST;
         cfg_ff.space_ticks     <= SPACE_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      case (reg_idx)
         REG_CARRIER_HIGH: csr_prdata = {24'd0, cfg_ff.carrier_high};
         REG_CARRIER_PER:  csr_prdata = {24'd0, cfg_ff.carrier_period};
         REG_PULSES_HALF:  csr_prdata = {26'd0, cfg_ff.pulses_per_half};
         REG_SPACE_TICKS:  csr_prdata = {20'd0, cfg_ff.space_ticks};
         default:          csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/rc5tx_engine.sv -----
// Frame state and Manchester/carrier timing of the RC5 transmitter.
// Depends on rc5tx_pkg; driven one item per enabled cycle.
module rc5tx_engine
   import rc5tx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step_en,
   input  logic       mode,
   input  logic [4:0] address,
   input  logic [5:0] command,
   output result_type result
);

   tx_state_type state_ff, state_in;
   logic [13:0]  shift_ff, shift_in;
   logic [3:0]   bitpos_ff, bitpos_in;
   logic         half_ff, half_in;
   logic [5:0]   pulse_ff, pulse_in;
   logic [11:0]  tick_ff, tick_in;
   logic         toggle_ff, toggle_in;

   logic        sending, in_burst, cur_level;
   logic [7:0]  period_lim;
   logic [5:0]  pulse_lim;
   logic [11:0] space_lim;
   logic [11:0] tick_inc;
   logic [5:0]  pulse_inc;
   logic        pulse_end, half_end;
   logic        done, refused;

   assign sending  = (state_ff == ST_SEND);
   assign in_burst = shift_ff[13] ? half_ff : ~half_ff;
   assign cur_level = sending & in_burst & (tick_ff < {4'd0, cfg.carrier_high});

   // Zero limits count as one
   assign period_lim = (cfg.carrier_period == 8'd0) ? 8'd1 : cfg.carrier_period;
   assign pulse_lim  = (cfg.pulses_per_half == 6'd0) ? 6'd1 : cfg.pulses_per_half;
   assign space_lim  = (cfg.space_ticks == 12'd0) ? 12'd1 : cfg.space_ticks;

   assign tick_inc  = tick_ff + 12'd1;
   assign pulse_inc = pulse_ff + 6'd1;
   assign pulse_end = in_burst & (tick_inc >= {4'd0, period_lim});
   assign half_end  = in_burst ? (pulse_end & (pulse_inc >= pulse_lim))
                               : (tick_inc >= space_lim);

   // Advance the frame by one item
   always_comb begin
      state_in  = state_ff;
      shift_in  = shift_ff;
      bitpos_in = bitpos_ff;
      half_in   = half_ff;
      pulse_in  = pulse_ff;
      tick_in   = tick_ff;
      toggle_in = toggle_ff;
      done      = 1'b0;
      refused   = 1'b0;
      if (step_en) begin
         if (mode == MODE_START) begin
            if (sending) begin
               refused = 1'b1;
            end else begin
               shift_in  = {2'b11, ~toggle_ff, address, command};
               toggle_in = ~toggle_ff;
               bitpos_in = 4'd0;
               half_in   = 1'b0;
               pulse_in  = 6'd0;
               tick_in   = 12'd0;
               state_in  = ST_SEND;
            end
         end else if (sending) begin
            tick_in = tick_inc;
            if (pulse_end) begin
               tick_in  = 12'd0;
               pulse_in = pulse_inc;
            end
            if (half_end) begin
               tick_in  = 12'd0;
               pulse_in = 6'd0;
               if (!half_ff) begin
                  half_in = 1'b1;
               end else begin
                  half_in = 1'b0;
                  if (bitpos_ff >= LAST_BIT) begin
                     state_in  = ST_IDLE;
                     done      = 1'b1;
                     bitpos_in = 4'd0;
                  end else begin
                     bitpos_in = bitpos_ff + 4'd1;
                     shift_in  = {shift_ff[12:0], 1'b0};
                  end
               end
            end
         end
      end
   end

   // Accepted start shows low; everything else shows the current level
   assign result.ir_level      = ((mode == MODE_START) && !sending) ? 1'b0 : cur_level;
   assign result.busy_res      = (state_in == ST_SEND);
   assign result.frame_done    = done;
   assign result.start_refused = refused;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         shift_ff  <= 14'd0;
         bitpos_ff <= 4'd0;
         half_ff   <= 1'b0;
         pulse_ff  <= 6'd0;
         tick_ff   <= 12'd0;
         toggle_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         shift_ff  <= shift_in;
         bitpos_ff <= bitpos_in;
         half_ff   <= half_in;
         pulse_ff  <= pulse_in;
         tick_ff   <= tick_in;
         toggle_ff <= toggle_in;
      end
   end

endmodule

// ----- hdl/rc5_ir_frame_transmitter.sv -----
// RC5 infrared frame transmitter: input register, timing engine, result register.
// Each transaction passes from the input register through the engine into the result register.
// Throughput: one item per cycle while the result side does not stall; the engine updates its state once per item.
// The result register lets a new item enter while a result waits to be taken.
// Reset (synchronous): registers to defaults, transmitter idle, pipeline empty.
// Depends on rc5tx_pkg, rc5tx_csr and rc5tx_engine.
module rc5_ir_frame_transmitter
   import rc5tx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [4:0]  req_address,
   input  logic [5:0]  req_command,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ir_level,
   output logic        rsp_busy_res,
   output logic        rsp_frame_done,
   output logic        rsp_start_refused,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type    cfg;
   result_type result;

   logic       in_valid_ff, in_valid_in;
   logic       in_mode_ff;
   logic [4:0] in_address_ff;
   logic [5:0] in_command_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   logic       advance, step_en;

   rc5tx_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Move the held item on when the result register is free
   assign advance   = ~out_valid_ff | ~rsp_stall;
   assign step_en   = in_valid_ff & advance;
   assign req_stall = in_valid_ff & ~advance;

   rc5tx_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step_en (step_en),
      .mode    (in_mode_ff),
      .address (in_address_ff),
      .command (in_command_ff),
      .result  (result)
   );

   // Input register
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_mode_ff    <= req_mode;
         in_address_ff <= req_address;
         in_command_ff <= req_command;
      end
   end

   // Result register: hold while stalled
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         out_ff <= result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_ir_level      = out_ff.ir_level;
   assign rsp_busy_res      = out_ff.busy_res;
   assign rsp_frame_done    = out_ff.frame_done;
   assign rsp_start_refused = out_ff.start_refused;

endmodule

// ----- hdl/rc5tx_checker.sv -----
// Port-level checker for the RC5 frame transmitter, bound to the top level.
// Depends on rc5_ir_frame_transmitter_assert.svh.
`include "rc5_ir_frame_transmitter_assert.svh"

module rc5tx_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_ir_level,
   input logic rsp_busy_res,
   input logic rsp_frame_done,
   input logic rsp_start_refused
);

   // A stalled result transaction stays and holds its payload
   `RC5TX_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable({rsp_ir_level, rsp_busy_res, rsp_frame_done, rsp_start_refused}), "rsp payload changed under stall")

   // The last half-bit leaves the transmitter idle
   `RC5TX_ASSERT_NOW(a_done_idle, clock, reset, rsp_valid && rsp_frame_done, !rsp_busy_res && !rsp_start_refused, "frame_done while busy")

   // A start is only refused while a frame is in flight
   `RC5TX_ASSERT_NOW(a_refused_busy, clock, reset, rsp_valid && rsp_start_refused, rsp_busy_res && !rsp_frame_done, "start refused while idle")

   // The LED only lights while a frame is being sent
   `RC5TX_ASSERT_NOW(a_level_busy, clock, reset, rsp_valid && rsp_ir_level, rsp_busy_res || rsp_frame_done, "ir_level high while idle")

endmodule

bind rc5_ir_frame_transmitter rc5tx_checker u_rc5tx_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_ir_level      (rsp_ir_level),
   .rsp_busy_res      (rsp_busy_res),
   .rsp_frame_done    (rsp_frame_done),
   .rsp_start_refused (rsp_start_refused)
);

// ----- dv/tb_rc5_ir_frame_transmitter.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the RC5 infrared frame transmitter: a clocked driver
// and monitor around the block, and a per-item predictor of the pin samples.
// Depends on rc5tx_pkg and rc5_ir_frame_transmitter.
module tb_rc5_ir_frame_transmitter;
   import rc5tx_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_ITEMS  = 1400;
   localparam int DIRECTED_SIZE = 22;

   typedef struct packed {
      logic       mode;
      logic [4:0] address;
      logic [5:0] command;
   } ir_request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   wire         req_stall;
   logic        req_mode = MODE_TICK;
   logic [4:0]  req_address = '0;
   logic [5:0]  req_command = '0;
   wire         rsp_valid;
   logic        rsp_stall = 1'b0;
   wire         rsp_ir_level;
   wire         rsp_busy_res;
   wire         rsp_frame_done;
   wire         rsp_start_refused;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   wire  [31:0] csr_prdata;
   wire         csr_pready;

   rc5_ir_frame_transmitter dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_address       (req_address),
      .req_command       (req_command),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ir_level      (rsp_ir_level),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_frame_done    (rsp_frame_done),
      .rsp_start_refused (rsp_start_refused),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // Pending transactions and the pin samples they are due to produce
   ir_request_type tx_requests[$];
   result_type  pins_due[$];
   int unsigned requests_queued = 0;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;
   bit          send_idle_on = 1'b1;
   bit          take_idle_on = 1'b1;

   // Transmitter shadow: timing registers and frame state
   cfg_type     tx_cfg;
   logic [13:0] tx_frame;
   logic [3:0]  tx_bit;
   logic        tx_second_half;
   logic [5:0]  tx_pulses;
   logic [11:0] tx_ticks;
   logic        tx_sending;
   logic        tx_toggle;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [11:0] floor_one(input logic [11:0] v);
      return (v == 12'd0) ? 12'd1 : v;
   endfunction

   // A one bit sends its space first, a zero bit its burst first
   function automatic logic tx_in_burst();
      return tx_frame[13] ? tx_second_half : ~tx_second_half;
   endfunction

   function automatic logic tx_pin();
      return tx_sending && tx_in_burst() && (tx_ticks < {4'd0, tx_cfg.carrier_high});
   endfunction

   function automatic int unsigned draw_wait(input bit on);
      return on ? $urandom_range(0, 19) : 0;
   endfunction

   // Advance the shadow by one transaction and queue the pin sample it yields
   task automatic predict_pin_sample(input ir_request_type rq);
      result_type r;
      logic       half_end;
      r = '0;
      half_end = 1'b0;
      if (rq.mode == MODE_START) begin
         if (tx_sending) begin
            r.start_refused = 1'b1;
         end else begin
            tx_frame       = {2'b11, ~tx_toggle, rq.address, rq.command};
            tx_toggle      = ~tx_toggle;
            tx_bit         = '0;
            tx_second_half = 1'b0;
            tx_pulses      = '0;
            tx_ticks       = '0;
            tx_sending     = 1'b1;
         end
         r.ir_level = tx_pin();
      end else if (tx_sending) begin
         r.ir_level = tx_pin();
         tx_ticks = tx_ticks + 12'd1;
         if (tx_in_burst()) begin
            if (tx_ticks >= floor_one({4'd0, tx_cfg.carrier_period})) begin
               tx_ticks  = '0;
               tx_pulses = tx_pulses + 6'd1;
               if ({6'd0, tx_pulses} >= floor_one({6'd0, tx_cfg.pulses_per_half}))
                  half_end = 1'b1;
            end
         end else if (tx_ticks >= floor_one(tx_cfg.space_ticks)) begin
            half_end = 1'b1;
         end
         if (half_end) begin
            tx_ticks  = '0;
            tx_pulses = '0;
            if (!tx_second_half) begin
               tx_second_half = 1'b1;
            end else begin
               tx_second_half = 1'b0;
               if (tx_bit >= LAST_BIT) begin
                  tx_sending   = 1'b0;
                  r.frame_done = 1'b1;
                  tx_bit       = '0;
               end else begin
                  tx_bit   = tx_bit + 4'd1;
                  tx_frame = tx_frame << 1;
               end
            end
         end
      end
      r.busy_res = tx_sending;
      pins_due.push_back(r);
   endtask

   task automatic check_field(input string name, input logic want, input logic got);
      if (got !== want) begin
         $error("%s: expected %0b, got %0b", name, want, got);
         mismatches++;
      end
   endtask

   // Driver: present queued transactions, hold them while stalled, idle between
   int unsigned send_wait;
   logic        send_next;
   ir_request_type send_item;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         send_next = req_valid;
         if (req_valid && !req_stall) begin
            predict_pin_sample('{req_mode, req_address, req_command});
            send_next = 1'b0;
            send_wait = draw_wait(send_idle_on);
         end
         if (!send_next) begin
            if (send_wait != 0) begin
               send_wait--;
            end else if (tx_requests.size() != 0) begin
               send_item = tx_requests.pop_front();
               req_mode    <= send_item.mode;
               req_address <= send_item.address;
               req_command <= send_item.command;
               send_next = 1'b1;
            end
         end
         req_valid <= send_next;
      end
   end

   // Monitor: take results with random stalls and compare with the oldest sample due
   int unsigned take_wait;
   result_type  take_want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         take_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pins_due.size() == 0) begin
               $error("result with no transaction pending");
               mismatches++;
            end else begin
               take_want = pins_due.pop_front();
               check_field("ir_level", take_want.ir_level, rsp_ir_level);
               check_field("busy_res", take_want.busy_res, rsp_busy_res);
               check_field("frame_done", take_want.frame_done, rsp_frame_done);
               check_field("start_refused", take_want.start_refused, rsp_start_refused);
            end
            take_wait = draw_wait(take_idle_on);
         end else if (take_wait != 0) begin
            take_wait--;
         end
         rsp_stall <= (take_wait != 0);
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL rc5_ir_frame_transmitter");
         $finish;
      end
   end

   task automatic push_request(input logic mode, input logic [4:0] address,
                               input logic [5:0] command);
      tx_requests.push_back('{mode, address, command});
      requests_queued++;
   endtask

   // Ticks carry random address and command, which the block must ignore
   task automatic push_ticks(input int unsigned count);
      for (int unsigned i = 0; i < count; i++)
         push_request(MODE_TICK, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
   endtask

   // Hold off until every transaction is through and the pipeline has emptied
   task automatic drain_block();
      do @(negedge clock);
      while (tx_requests.size() != 0 || req_valid || pins_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (csr_pready !== 1'b1);
      case (index)
         REG_CARRIER_HIGH: tx_cfg.carrier_high    = value[7:0];
         REG_CARRIER_PER:  tx_cfg.carrier_period  = value[7:0];
         REG_PULSES_HALF:  tx_cfg.pulses_per_half = value[5:0];
         REG_SPACE_TICKS:  tx_cfg.space_ticks     = value[11:0];
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Write all four timing registers, with random junk above the field half the time
   task automatic set_timing(input logic [7:0] high, input logic [7:0] period,
                             input logic [5:0] pulses, input logic [11:0] space);
      logic [31:0] junk;
      junk = ($urandom_range(0, 1) == 1) ? $urandom() : 32'd0;
      csr_write(REG_CARRIER_HIGH, {junk[31:8], high});
      csr_write(REG_CARRIER_PER, {junk[31:8], period});
      csr_write(REG_PULSES_HALF, {junk[31:6], pulses});
      csr_write(REG_SPACE_TICKS, {junk[31:12], space});
      @(negedge clock);
   endtask

   // One random phase: new timing, then mostly a whole frame of ticks with some
   // stray starts; some phases stop mid-frame so the next timing lands in a frame
   typedef enum int { PHASE_SMALL, PHASE_WIDE, PHASE_MAX } phase_kind_type;
   task automatic random_phase(input phase_kind_type kind);
      int unsigned h, p, n, s, span, count;
      drain_block();
      case (kind)
         PHASE_MAX: begin
            h = 255; p = 255; n = 63; s = 4095;
         end
         PHASE_WIDE: begin
            h = $urandom_range(0, 255);
            p = $urandom_range(128, 255);
            n = $urandom_range(32, 63);
            s = $urandom_range(2048, 4095);
         end
         default: begin
            h = $urandom_range(0, 5);
            p = $urandom_range(0, 5);
            n = $urandom_range(0, 3);
            s = $urandom_range(0, 6);
         end
      endcase
      set_timing(8'(h), 8'(p), 6'(n), 12'(s));
      send_idle_on = ($urandom_range(0, 3) != 0);
      take_idle_on = ($urandom_range(0, 3) != 0);
      span = 14 * (int'(floor_one(12'(n))) * int'(floor_one(12'(p))) +
                   int'(floor_one(12'(s))));
      if (kind != PHASE_SMALL)
         count = $urandom_range(40, 150);
      else if ($urandom_range(0, 3) == 0)
         count = $urandom_range(1, span);
      else
         count = span + $urandom_range(0, 8);
      push_ticks($urandom_range(0, 3));
      push_request(MODE_START, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
      for (int unsigned i = 0; i < count; i++) begin
         if ($urandom_range(0, 39) == 0)
            push_request(MODE_START, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
         else
            push_ticks(1);
      end
   endtask

   // Stimulus: directed cases, then random phases, then drain and report
   initial begin
      tx_cfg         = '{CARRIER_HIGH_RST, CARRIER_PER_RST, PULSES_HALF_RST, SPACE_TICKS_RST};
      tx_frame       = '0;
      tx_bit         = '0;
      tx_second_half = 1'b0;
      tx_pulses      = '0;
      tx_ticks       = '0;
      tx_sending     = 1'b0;
      tx_toggle      = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset timing: ticks while idle, a start, a refused start
      push_request(MODE_TICK, 5'd31, 6'd63);
      push_request(MODE_TICK, 5'd0, 6'd0);
      push_request(MODE_START, 5'd31, 6'd63);
      push_request(MODE_START, 5'd0, 6'd0);
      push_ticks(3);
      drain_block();

      // Shrink the limits mid-frame so the running counters are already past them
      set_timing(8'd1, 8'd2, 6'd1, 12'd1);
      push_request(MODE_START, 5'd21, 6'd42);
      push_ticks(4);
      drain_block();

      // Zero period, pulse count and space, with no high time
      set_timing(8'd0, 8'd0, 6'd0, 12'd0);
      send_idle_on = 1'b0;
      take_idle_on = 1'b0;
      push_ticks(4);
      drain_block();

      // High time above the period keeps the pin high through each pulse
      set_timing(8'd255, 8'd3, 6'd2, 12'd2);
      send_idle_on = 1'b1;
      take_idle_on = 1'b1;
      push_ticks(6);

      random_phase(PHASE_MAX);
      while (requests_queued < RANDOM_ITEMS + DIRECTED_SIZE)
         random_phase(($urandom_range(0, 9) == 0) ? PHASE_WIDE : PHASE_SMALL);

      drain_block();
      repeat (10) @(posedge clock);
      if (pins_due.size() != 0) begin
         $error("%0d results never arrived", pins_due.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("PASS rc5_ir_frame_transmitter");
      else
         $display("FAIL rc5_ir_frame_transmitter");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/rc5tx_pkg.sv
hdl/rc5tx_csr.sv
hdl/rc5tx_engine.sv
hdl/rc5_ir_frame_transmitter.sv
hdl/rc5tx_checker.sv
dv/tb_rc5_ir_frame_transmitter.sv
